// File: rtl/raf_pkg.sv
package raf_pkg;

  localparam int WINDOW   = 20;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = SAMPLE_W + ((WINDOW > 1) ? $clog2(WINDOW) : 1);
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int STEP_W   = $clog2(SUM_W);

  // sample queue between the front and back parts
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic    valid;
    sample_t data;
  } queue_out_t;

endpackage

// File: rtl/raf_queue.sv
module raf_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  raf_pkg::sample_t    s_tdata,
  output raf_pkg::queue_out_t head,
  input  logic                pop
);
  import raf_pkg::*;

  sample_t            mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               take;

  assign s_tready = (count != QCNT_W'(QDEPTH));
  assign push     = s_tvalid && s_tready;
  assign take     = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/raf_core.sv
module raf_core (
  input  logic                clk,
  input  logic                rst,
  input  raf_pkg::queue_out_t head,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output raf_pkg::sample_t    m_tdata
);
  import raf_pkg::*;

  typedef enum logic {S_IDLE, S_DIV} state_t;

  state_t            state;
  sample_t           ring [WINDOW];
  logic [POS_W-1:0]  wr_pos;
  logic [POS_W-1:0]  wr_pos_next;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_next;
  logic              full;
  sample_t           old;

  logic [SUM_W-1:0]  quo;
  logic [SUM_W-1:0]  quo_next;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  rem_next;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              ge;
  logic [STEP_W-1:0] step;
  logic              last_step;
  logic              out_free;
  logic              finish;

  // entries past the fill point were never written and count as zero
  assign full = (fill == CNT_W'(WINDOW));
  assign old  = full ? ring[wr_pos] : '0;

  always_comb begin
    sum_next    = sum - SUM_W'(old) + SUM_W'(head.data);
    wr_pos_next = (wr_pos == POS_W'(WINDOW - 1)) ? '0 : wr_pos + 1'b1;
    fill_next   = full ? fill : fill + 1'b1;
  end

  // restoring divider, one quotient bit per cycle; the last bit waits for a free output
  always_comb begin
    shifted  = {rem, quo[SUM_W-1]};
    diff     = shifted - {1'b0, fill};
    ge       = (shifted >= {1'b0, fill});
    rem_next = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
    quo_next = {quo[SUM_W-2:0], ge};
  end

  assign last_step = (step == STEP_W'(SUM_W - 1));
  assign out_free  = !m_tvalid || m_tready;
  assign finish    = (state == S_DIV) && last_step && out_free;
  assign pop       = (state == S_IDLE) && head.valid;

  always_ff @(posedge clk) begin
    if (pop) begin
      ring[wr_pos] <= head.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wr_pos   <= '0;
      sum      <= '0;
      fill     <= '0;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= finish || (m_tvalid && !m_tready);
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            sum    <= sum_next;
            wr_pos <= wr_pos_next;
            fill   <= fill_next;
            quo    <= sum_next;
            rem    <= '0;
            step   <= '0;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (!last_step) begin
            quo  <= quo_next;
            rem  <= rem_next;
            step <= step + 1'b1;
          end else if (out_free) begin
            // final bit lands straight in the output register
            m_tdata <= quo_next[SAMPLE_W-1:0];
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/running_average_filter_unit.sv
// Running average filter: mean of the last WINDOW (20) unsigned 16-bit samples.
//
// Input channel s_*: one sample per request, tdata = sample[15:0].
// Output channel m_*: one result per sample, tdata = average[15:0], the sum
// of the stored samples divided by the number seen so far (up to WINDOW),
// truncated.
//
// A two-entry queue takes samples while the back end works; the back end
// updates the ring and running sum as it takes a sample, then runs a
// restoring divider at one quotient bit per cycle (21 bits), the last
// bit waiting while the receiver stalls. It takes the next sample from
// the queue only after the divider has finished the previous one.
//
// Reset clears the queue, position, sum and fill count; ring contents are
// treated as zero until written. If the receiver stalls, the result holds
// in the output register, the divider waits on its last step, and the queue
// keeps taking up to two more samples before s_tready drops.
module running_average_filter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [15:0] average
);
  import raf_pkg::*;

  queue_out_t head;
  logic       pop;

  raf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .head     (head),
    .pop      (pop)
  );

  raf_core u_core (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: rtl/raf_checker.sv
module raf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output request dropped or changed while stalled");

  // reset empties output register and queue
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("not cleared after reset");

  // a result needs at least a sample taken earlier; none right out of reset
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result without a sample");

  // a valid result carries defined data
  a_out_known: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !$isunknown(m_tdata))
    else $error("output request with unknown data");

  // an accepted sample carries defined data
  a_in_known: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !$isunknown(s_tdata))
    else $error("input request with unknown data");

endmodule

bind running_average_filter_unit raf_checker u_raf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
